// File: src/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg: shared types for the sorted character multiset
// Command and status codes, sequencer states and the result word.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_DEL_RD,
        S_DEL_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [4:0]  count;
        logic [7:0]  smallest;
    } t_result;

endpackage

// File: src/scm_if.sv
// ----------------------------------------------------------------------------
// scm_if: valid/ready channels of the sorted character multiset
// Command channel (cmd, ch) and result channel (status, count, smallest).
// ----------------------------------------------------------------------------
interface scm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink   (input valid, input cmd, input ch, output ready);
endinterface

interface scm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] count;
    logic [7:0] smallest;

    modport source (output valid, output status, output count, output smallest, input ready);
    modport sink   (input valid, input status, input count, input smallest, output ready);
endinterface

// File: src/scm_ram.sv
// ----------------------------------------------------------------------------
// scm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl: insert/delete sequencer over the entry RAM
// Insert walks down from the top, moving entries >= ch up one slot.
// Delete walks up, finds the first match and pulls later entries down.
// ----------------------------------------------------------------------------
module scm_ctrl
    import scm_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_cmd,
    input  logic [7:0] i_ch,
    input  logic    i_out_free,
    output logic    o_idle,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_count;
    logic [7:0]      r_ch;
    logic            r_found;
    logic [7:0]      r_smallest;
    t_status         r_status;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic [CW-1:0]   idx_m1;
    logic            is_full;
    logic            is_empty;
    logic [CW+4:0]   count_ext;

    assign idx_m1   = r_idx - 1'b1;
    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);

    scm_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_INSERT) begin
                        n_state = is_full ? S_DONE : S_INS_RD;
                    end else begin
                        n_state = is_empty ? S_DONE : S_DEL_RD;
                    end
                end
            end
            S_INS_RD: n_state = (r_idx == '0) ? S_DONE : S_INS_EV;
            S_INS_EV: n_state = (ram_rdata >= r_ch) ? S_INS_RD : S_DONE;
            S_DEL_RD: n_state = (r_idx == r_count) ? S_DONE : S_DEL_EV;
            S_DEL_EV: n_state = S_DEL_RD;
            S_DONE:   n_state = i_out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = r_ch;
        ram_raddr = idx_m1[AW-1:0];
        o_idle    = 1'b0;
        o_done    = 1'b0;
        case (r_state)
            S_IDLE: o_idle = 1'b1;
            S_INS_RD: begin
                ram_we = (r_idx == '0);
            end
            S_INS_EV: begin
                ram_we    = 1'b1;
                ram_wdata = (ram_rdata >= r_ch) ? ram_rdata : r_ch;
            end
            S_DEL_RD: begin
                ram_raddr = r_idx[AW-1:0];
            end
            S_DEL_EV: begin
                ram_we    = r_found;
                ram_waddr = idx_m1[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_DONE:  o_done = i_out_free;
            default: o_idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ch     <= i_ch;
                        r_found  <= 1'b0;
                        r_status <= ST_OK;
                        if (i_cmd == CMD_INSERT) begin
                            r_idx <= r_count;
                            if (is_full) begin
                                r_status <= ST_FULL;
                            end
                        end else begin
                            r_idx <= '0;
                            if (is_empty) begin
                                r_status <= ST_EMPTY;
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    if (r_idx == '0) begin
                        r_smallest <= r_ch;
                        r_count    <= r_count + 1'b1;
                    end
                end
                S_INS_EV: begin
                    if (ram_rdata >= r_ch) begin
                        r_idx <= idx_m1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_DEL_RD: begin
                    if (r_idx == r_count) begin
                        if (r_found) begin
                            r_count <= r_count - 1'b1;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end
                end
                S_DEL_EV: begin
                    if (r_found && idx_m1 == '0) begin
                        r_smallest <= ram_rdata;
                    end
                    if (!r_found && ram_rdata == r_ch) begin
                        r_found <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                default: r_found <= r_found;
            endcase
        end
    end

    assign count_ext = {5'd0, r_count};

    assign o_result.status   = r_status;
    assign o_result.count    = count_ext[4:0];
    assign o_result.smallest = is_empty ? 8'd0 : r_smallest;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_RD || r_state == S_INS_EV) |-> !is_full)
        else $error("insert walk on a full store");

    a_ins_ev_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_EV |-> r_idx != '0)
        else $error("insert move at slot zero");

    a_del_shift_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL_EV && r_found) |-> r_idx != '0)
        else $error("delete pull-down with no lower slot");

endmodule

// File: src/sorted_char_multiset.sv
// ----------------------------------------------------------------------------
// sorted_char_multiset: bounded sorted multiset of bytes
// Top level: command sequencer, entry RAM and result register.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries one word per command: cmd (0 insert, 1 delete) and ch.
//   o_out returns one word per command: status, count and smallest entry.
//   Insert puts ch before the first entry >= ch; delete removes the first
//   entry equal to ch. Full, empty and not-found leave the store unchanged.
//   A command is taken only while the sequencer is idle. Each step of the
//   walk is a RAM read state followed by an evaluate/write state.
//   The result register frees the sequencer once loaded; if the sink stalls
//   with a word still held, the next result waits in the sequencer and no
//   further command is taken. Reset empties the store (count 0); entry RAM
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_char_multiset
    import scm_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scm_in_if.sink           i_in,
    scm_out_if.source        o_out
);

    logic    r_valid;
    t_result r_result;
    logic    out_free;
    logic    seq_idle;
    logic    seq_done;
    t_result seq_result;

    assign out_free   = !r_valid || o_out.ready;
    assign i_in.ready = seq_idle;

    scm_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in.valid && seq_idle),
        .i_cmd      (i_in.cmd),
        .i_ch       (i_in.ch),
        .i_out_free (out_free),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_result   (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (seq_done) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_result <= seq_result;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.status   = r_result.status;
    assign o_out.count    = r_result.count;
    assign o_out.smallest = r_result.smallest;

    a_empty_smallest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.count == 5'd0 && CAPACITY < 32) |-> o_out.smallest == 8'd0)
        else $error("empty store reports nonzero smallest");

    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> (!r_valid || o_out.ready))
        else $error("result pushed over a held word");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("command taken while sequencer busy");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_char_multiset
// Streams insert/delete words through the command channel with bursty
// sending and a stalling result sink, predicts each result from a sorted
// byte queue and compares every returned word field by field.
// ----------------------------------------------------------------------------
module testbench
    import scm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 16;
    localparam int CLK_NS       = 12;
    localparam int RANDOM_WORDS = 1300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 500;

    typedef struct {
        logic       cmd;
        logic [7:0] ch;
        bit         drain_first;
    } t_cmd_word;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} t_rx_mode;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic i_clk;
    logic i_rst_n;

    scm_in_if  cmd_ch();
    scm_out_if res_ch();

    sorted_char_multiset #(.CAPACITY(CAPACITY)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    t_cmd_word  pending[$];
    t_result    results_due[$];
    logic [7:0] held[$];

    int       total_words = 0;
    int       words_in    = 0;
    int       words_out   = 0;
    int       mismatches  = 0;
    bit       in_fire     = 1'b0;
    bit       rx_hold     = 1'b0;
    int       burst_left  = 0;
    int       gap_left    = 0;
    int       mode_left   = 0;
    t_rx_mode rx_mode     = RX_FREE;

    // sorted multiset update; equal bytes go in front of older copies
    function automatic t_result multiset_step(logic cmd, logic [7:0] ch);
        t_result r;
        int      pos;
        pos = 0;
        if (cmd == CMD_INSERT) begin
            if (held.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                while (pos < held.size() && held[pos] < ch) pos++;
                held.insert(pos, ch);
                r.status = ST_OK;
            end
        end else if (held.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            while (pos < held.size() && held[pos] != ch) pos++;
            if (pos >= held.size()) begin
                r.status = ST_NOT_FOUND;
            end else begin
                held.delete(pos);
                r.status = ST_OK;
            end
        end
        r.count    = 5'(held.size());
        r.smallest = (held.size() > 0) ? held[0] : 8'h00;
        return r;
    endfunction

    task automatic queue_word(logic cmd, logic [7:0] ch, bit drain_first);
        t_cmd_word w;
        w.cmd         = cmd;
        w.ch          = ch;
        w.drain_first = drain_first;
        pending.push_back(w);
        total_words++;
    endtask

    task automatic log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(CLK_NS / 2) i_clk = ~i_clk;
    end

    initial begin
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = CMD_INSERT;
        cmd_ch.ch    = 8'h00;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // stimulus: directed corner cases, then phased random traffic
    initial begin
        int         n;
        int         phase_len;
        int         ins_pct;
        int         span;
        bit         narrow;
        bit         is_del;
        t_mix       mix;
        logic [7:0] base;
        logic [7:0] ch;

        queue_word(CMD_DELETE, 8'h10, 1'b0);
        queue_word(CMD_INSERT, 8'h80, 1'b0);
        queue_word(CMD_INSERT, 8'h00, 1'b0);
        queue_word(CMD_INSERT, 8'hFF, 1'b0);
        queue_word(CMD_INSERT, 8'h80, 1'b0);
        queue_word(CMD_DELETE, 8'h40, 1'b0);
        queue_word(CMD_DELETE, 8'h80, 1'b0);
        queue_word(CMD_DELETE, 8'h00, 1'b0);
        for (int i = 0; i < 14; i++) queue_word(CMD_INSERT, 8'(8'h7F - 9 * i), 1'b0);
        queue_word(CMD_INSERT, 8'h55, 1'b0);
        queue_word(CMD_DELETE, 8'hFF, 1'b0);
        queue_word(CMD_DELETE, 8'hFF, 1'b0);

        n    = 0;
        base = 8'($urandom_range(0, 255));
        while (n < RANDOM_WORDS) begin
            phase_len = $urandom_range(8, 48);
            mix       = t_mix'($urandom_range(0, 2));
            ins_pct   = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
            if ($urandom_range(0, 9) < 3) base = 8'($urandom_range(0, 255));
            narrow = ($urandom_range(0, 9) < 7);
            span   = ($urandom_range(0, 3) == 0) ? 1 : 7;
            repeat (phase_len) begin
                is_del = ($urandom_range(0, 99) >= ins_pct);
                ch     = narrow ? 8'(base + $urandom_range(0, span))
                                : 8'($urandom_range(0, 255));
                queue_word(is_del ? CMD_DELETE : CMD_INSERT, ch, n == 300 || n == 1000);
                n++;
            end
        end
    end

    // command sender: bursts of words separated by random gaps
    always @(negedge i_clk) begin
        t_cmd_word nxt;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.cmd   <= CMD_INSERT;
            cmd_ch.ch    <= 8'h00;
        end else if (in_fire || !cmd_ch.valid) begin
            if (gap_left > 0) begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end else if (pending.size() != 0 &&
                         !(pending[0].drain_first && results_due.size() != 0)) begin
                nxt = pending.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.cmd   <= nxt.cmd;
                cmd_ch.ch    <= nxt.ch;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: the stall pattern switches among free, coin-toss and sparse modes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:   res_ch.ready <= !rx_hold;
                RX_COIN:   res_ch.ready <= !rx_hold && ($urandom_range(0, 1) == 1);
                default:   res_ch.ready <= !rx_hold && ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // long sink hold-off so the block backs up and stalls its input
    initial begin
        while (words_in < HOLD_AFTER) @(negedge i_clk);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result want;
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                results_due.push_back(multiset_step(cmd_ch.cmd, cmd_ch.ch));
                words_in++;
                in_fire = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                words_out++;
                if (results_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected word status=%0d count=%0d smallest=%02h",
                                           res_ch.status, res_ch.count, res_ch.smallest));
                end else begin
                    want = results_due.pop_front();
                    if (res_ch.status !== want.status || res_ch.count !== want.count ||
                        res_ch.smallest !== want.smallest)
                        log_mismatch($sformatf(
                            "word %0d status %0d/%0d count %0d/%0d smallest %02h/%02h",
                            words_out, res_ch.status, want.status, res_ch.count,
                            want.count, res_ch.smallest, want.smallest));
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (total_words == 0 || words_in < total_words || results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_NS);
        $display("testbench: errors");
        $finish;
    end

endmodule

// File: sorted_char_multiset.f
src/scm_pkg.sv
src/scm_if.sv
src/scm_ram.sv
src/scm_ctrl.sv
src/sorted_char_multiset.sv
tb/testbench.sv
